// ----- src/rnrd_pkg.sv -----
// ----------------------------------------------------------------------------
// rnrd_pkg
// Shared sizes, field widths and sequencer states of the raster nibble
// run-length decoder.
// ----------------------------------------------------------------------------
package rnrd_pkg;

    // Raster limits
    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 512;

    // Counter widths follow from the limits
    localparam int CELL_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS);

    // Fixed field widths of the streams
    localparam int BYTE_W  = 8;
    localparam int RUN_W   = 4;
    localparam int COLOR_W = 4;
    localparam int POS_W   = 9;
    localparam int OUT_W   = COLOR_W + 2 * POS_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [CELL_W-1:0] CELL_LIMIT = CELL_W'(MAX_COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(MAX_ROWS - 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } rnrd_state_t;

endpackage

// ----- src/raster_nibble_rle_decoder_core.sv -----
// ----------------------------------------------------------------------------
// raster_nibble_rle_decoder_core
// Run-length raster decoder: one byte in, up to fifteen tagged cells out.
// ----------------------------------------------------------------------------
// Input stream (s_): one word per coded byte. tdata[7:4] is the run length,
// tdata[3:0] the color. tuser[0] marks the first byte of a raster (restarts
// row 0), tuser[1] the first byte of a row; packet start wins if both are set.
// Output stream (m_): one word per decoded cell, tlast on the final word of a
// byte. tuser[0] flags an overflow word: the row ran past the column count
// set by row 0, no pixel is carried and the rest of that row is dropped.
// Operation: a byte is taken while the sequencer is idle, then the sequencer
// walks its run with one shared compare/increment unit on the cell counter,
// producing one word per cycle while the output register is free (no word is
// produced while a held word waits on m_tready).
// s_tready is low while a run is being walked.
// Receiver stall: the output register holds its word while m_tready is low
// and the sequencer waits; no word is dropped. The next byte may be taken
// while the last word of the previous one still sits in the output register.
// Reset (aresetn low, synchronous): column count 0, row 0, first-row mode,
// output empty, sequencer idle.
// ----------------------------------------------------------------------------
module raster_nibble_rle_decoder_core
    import rnrd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] rle_byte
    input  logic [1:0]             s_tuser,   // [0] packet_begin, [1] row_begin
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [3:0] color, [12:4] column,
                                              // [21:13] row, [23:22] zero
    output logic                   m_tuser,   // [0] overflow
    output logic                   m_tlast
);

    // Sequencer and decoder state
    rnrd_state_t        state_reg, state_next;
    logic [CELL_W-1:0]  column_total_reg, column_total_next;
    logic [CELL_W-1:0]  cell_index_reg, cell_index_next;
    logic [ROW_W-1:0]   row_index_reg, row_index_next;
    logic               in_first_row_reg, in_first_row_next;
    logic               row_failed_reg, row_failed_next;
    logic [RUN_W-1:0]   run_left_reg, run_left_next;
    logic [COLOR_W-1:0] color_reg, color_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic [COLOR_W-1:0] m_color_reg, m_color_next;
    logic [POS_W-1:0]   m_column_reg, m_column_next;
    logic [POS_W-1:0]   m_row_reg, m_row_next;
    logic               m_ovf_reg, m_ovf_next;
    logic               m_last_reg, m_last_next;

    // Shared unit: one compare and one increment on the cell counter
    logic [CELL_W-1:0]  cmp_limit;
    logic               cell_at_limit;
    logic [CELL_W-1:0]  cell_inc;
    logic               out_free;
    logic               s_accept;

    assign cmp_limit     = in_first_row_reg ? CELL_LIMIT : column_total_reg;
    assign cell_at_limit = (cell_index_reg >= cmp_limit);
    assign cell_inc      = cell_index_reg + CELL_W'(1);
    assign out_free      = !m_valid_reg || m_tready;
    assign s_tready      = (state_reg == ST_IDLE);
    assign s_accept      = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({m_row_reg, m_column_reg, m_color_reg});
    assign m_tuser  = m_ovf_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            column_total_reg <= '0;
            cell_index_reg   <= '0;
            row_index_reg    <= '0;
            in_first_row_reg <= 1'b1;
            row_failed_reg   <= 1'b0;
            run_left_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            column_total_reg <= column_total_next;
            cell_index_reg   <= cell_index_next;
            row_index_reg    <= row_index_next;
            in_first_row_reg <= in_first_row_next;
            row_failed_reg   <= row_failed_next;
            run_left_reg     <= run_left_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge aclk) begin
        color_reg    <= color_next;
        m_color_reg  <= m_color_next;
        m_column_reg <= m_column_next;
        m_row_reg    <= m_row_next;
        m_ovf_reg    <= m_ovf_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next        = state_reg;
        column_total_next = column_total_reg;
        cell_index_next   = cell_index_reg;
        row_index_next    = row_index_reg;
        in_first_row_next = in_first_row_reg;
        row_failed_next   = row_failed_reg;
        run_left_next     = run_left_reg;
        color_next        = color_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_color_next      = m_color_reg;
        m_column_next     = m_column_reg;
        m_row_next        = m_row_reg;
        m_ovf_next        = m_ovf_reg;
        m_last_next       = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    // Apply the markers, then load the run
                    if (s_tuser[0]) begin
                        column_total_next = '0;
                        cell_index_next   = '0;
                        row_index_next    = '0;
                        in_first_row_next = 1'b1;
                        row_failed_next   = 1'b0;
                    end else if (s_tuser[1]) begin
                        in_first_row_next = 1'b0;
                        cell_index_next   = '0;
                        row_failed_next   = 1'b0;
                        if (row_index_reg < ROW_LAST) begin
                            row_index_next = row_index_reg + ROW_W'(1);
                        end
                    end
                    run_left_next = s_tdata[BYTE_W-1 -: RUN_W];
                    color_next    = s_tdata[COLOR_W-1:0];
                    state_next    = ST_RUN;
                end
            end

            ST_RUN: begin
                // Drop the byte when nothing is left to emit
                if (run_left_reg == '0 || (in_first_row_reg && cell_at_limit) ||
                    (!in_first_row_reg && row_failed_reg)) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_column_next = POS_W'(cell_index_reg);
                    m_row_next    = POS_W'(row_index_reg);
                    run_left_next = run_left_reg - RUN_W'(1);
                    if (!in_first_row_reg && cell_at_limit) begin
                        // Overflow word ends the byte and fails the row
                        m_color_next    = '0;
                        m_ovf_next      = 1'b1;
                        m_last_next     = 1'b1;
                        row_failed_next = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        m_color_next    = color_reg;
                        m_ovf_next      = 1'b0;
                        cell_index_next = cell_inc;
                        if (in_first_row_reg) begin
                            column_total_next = cell_inc;
                            m_last_next = (run_left_reg == RUN_W'(1)) ||
                                          (cell_inc >= CELL_LIMIT);
                        end else begin
                            m_last_next = (run_left_reg == RUN_W'(1));
                        end
                        if (m_last_next) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An overflow word always closes the words of its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("overflow word without tlast");

    // Row 0 never fails; only later rows can overflow
    assert property (@(posedge aclk) disable iff (!aresetn)
        row_failed_reg |-> !in_first_row_reg)
        else $error("row failure flagged in row 0");

    // Column count never exceeds the raster limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        column_total_reg <= CELL_LIMIT && cell_index_reg <= CELL_LIMIT)
        else $error("cell counter past column limit");

    // A word in row 0 is emitted only below the column limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN && m_valid_next && !m_valid_reg && in_first_row_reg
        |-> cell_index_reg < CELL_LIMIT)
        else $error("row 0 cell emitted past limit");

endmodule
